### hw/rtl/q2e_pkg.sv
// ---------------------------------------------------------------------------
// q2e_pkg
// Shared widths, angle constants, step angle table and helper types for the
// quaternion to Euler angle pipeline.
// ---------------------------------------------------------------------------
package q2e_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int N_ITER = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;

	// Square root cells: one result bit per cell, 29 bits for a 57-bit radicand.
	localparam int NSQ = 29;
	localparam int RW  = 57;

	localparam int IW  = 16;
	localparam int PW  = 32;
	localparam int TW  = 36;
	localparam int CW  = 40;
	localparam int AW  = 21;
	localparam int THW = 11;

	localparam logic signed [AW-1:0] ANG_PI      = AW'(205887);
	localparam logic signed [AW-1:0] ANG_HALF_PI = AW'(102944);
	localparam logic signed [AW-1:0] ANG_TWO_PI  = AW'(411775);
	localparam logic signed [AW-1:0] ANG_TENTH   = AW'(114);
	localparam logic signed [AW:0]   OUT_LIMIT   = (AW+1)'(25736);
	localparam logic signed [TW-1:0] ONE_Q28     = TW'(64'sd268435456);

	typedef struct packed {
		logic signed [TW-1:0] sr;
		logic signed [TW-1:0] cr;
		logic signed [TW-1:0] sy;
		logic signed [TW-1:0] cy;
		logic signed [TW-1:0] sp;
		logic                 sat_pos;
		logic                 sat_neg;
		logic                 yzero;
	} side_t;

	typedef struct packed {
		logic sat_pos;
		logic sat_neg;
		logic yzero;
	} flag_t;

	// round(atan(2^-i) * 65536)
	function automatic logic signed [AW-1:0] step_angle(input logic [4:0] i);
		logic signed [AW-1:0] a;
		case (i)
			5'd0:    a = AW'(51472);
			5'd1:    a = AW'(30386);
			5'd2:    a = AW'(16055);
			5'd3:    a = AW'(8150);
			5'd4:    a = AW'(4091);
			5'd5:    a = AW'(2047);
			5'd6:    a = AW'(1024);
			5'd7:    a = AW'(512);
			5'd8:    a = AW'(256);
			5'd9:    a = AW'(128);
			5'd10:   a = AW'(64);
			5'd11:   a = AW'(32);
			5'd12:   a = AW'(16);
			5'd13:   a = AW'(8);
			5'd14:   a = AW'(4);
			5'd15:   a = AW'(2);
			5'd16:   a = AW'(1);
			default: a = '0;
		endcase
		return a;
	endfunction

	// Round an angle with 16 fraction bits to 13 fraction bits and saturate.
	function automatic logic [15:0] to_out(input logic signed [AW-1:0] a);
		logic signed [AW:0] t;
		logic signed [AW:0] v;
		t = (AW+1)'(a) + (AW+1)'(4);
		v = t >>> 3;
		if (v > OUT_LIMIT) begin
			v = OUT_LIMIT;
		end
		if (v < -OUT_LIMIT) begin
			v = -OUT_LIMIT;
		end
		return v[15:0];
	endfunction

endpackage

### hw/rtl/quaternion_to_euler_angles.sv
// ---------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q2.14 quaternion into roll, pitch and yaw in Q3.13 radians.
// ---------------------------------------------------------------------------
// The block takes one quaternion per clock while the output is not
// stalled and returns one result per quaternion, in order. Products and
// terms are registered first, then the radicand, then the bit-serial square
// root chain for the pitch cosine, then the CORDIC chains (one pre-rotation
// plus 16 micro-rotation cells), then quadrant correction and rounding
// registers. The whole pipeline holds when the output is stalled. Write
// yaw_zero_threshold only while no transfer is in flight.
module quaternion_to_euler_angles (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,   // yaw_zero_threshold
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,       // quat_w, quat_x, quat_y, quat_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata        // roll_angle, pitch_angle, yaw_angle, pitch_quadrant
);
	import q2e_pkg::*;

	localparam int LAT = 3 + NSQ + (N_ITER + 1) + 2;

	logic                 adv;
	logic [THW-1:0]       thr_q;
	logic [LAT-1:0]       vld_q;

	logic signed [PW-1:0] wx_s1, yz_s1, xx_s1, yy_s1, wy_s1, zx_s1, wz_s1, xy_s1, zz_s1;
	logic signed [TW-1:0] sr_c, cr_c, sp_c, sy_c, cy_c, acy_c;
	side_t                sb_s2, sb_s3;
	logic [RW-1:0]        rem_s3;
	logic [TW-1:0]        spm_c;
	logic [2*28-1:0]      sq_c;

	logic [RW-1:0]        n_w [NSQ+1];
	logic [RW-1:0]        r_w [NSQ+1];
	side_t                sb_d [NSQ];
	flag_t                fl_d [N_ITER+1];

	logic signed [AW-1:0] roll_c, pitch_c, yaw_c;
	logic signed [AW-1:0] r_c, p_c, y_c;
	logic signed [AW-1:0] roll_s4, pitch_s4, yaw_s4;
	logic signed [AW-1:0] pq_c;
	logic [2:0]           quad_c;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THW'(1);
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Stage 1: products of the quaternion components.
	always_ff @(posedge clk) begin
		if (adv) begin
			wx_s1 <= $signed(s_tdata[15:0])  * $signed(s_tdata[31:16]);
			yz_s1 <= $signed(s_tdata[47:32]) * $signed(s_tdata[63:48]);
			xx_s1 <= $signed(s_tdata[31:16]) * $signed(s_tdata[31:16]);
			yy_s1 <= $signed(s_tdata[47:32]) * $signed(s_tdata[47:32]);
			wy_s1 <= $signed(s_tdata[15:0])  * $signed(s_tdata[47:32]);
			zx_s1 <= $signed(s_tdata[63:48]) * $signed(s_tdata[31:16]);
			wz_s1 <= $signed(s_tdata[15:0])  * $signed(s_tdata[63:48]);
			xy_s1 <= $signed(s_tdata[31:16]) * $signed(s_tdata[47:32]);
			zz_s1 <= $signed(s_tdata[63:48]) * $signed(s_tdata[63:48]);
		end
	end

	// Stage 2: sine and cosine terms in Q.28.
	always_comb begin
		sr_c  = (TW'(wx_s1) + TW'(yz_s1)) <<< 1;
		cr_c  = ONE_Q28 - ((TW'(xx_s1) + TW'(yy_s1)) <<< 1);
		sp_c  = (TW'(wy_s1) - TW'(zx_s1)) <<< 1;
		sy_c  = (TW'(wz_s1) + TW'(xy_s1)) <<< 1;
		cy_c  = ONE_Q28 - ((TW'(yy_s1) + TW'(zz_s1)) <<< 1);
		acy_c = (cy_c < 0) ? -cy_c : cy_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s2.sr      <= sr_c;
			sb_s2.cr      <= cr_c;
			sb_s2.sp      <= sp_c;
			sb_s2.sy      <= sy_c;
			sb_s2.cy      <= cy_c;
			sb_s2.sat_pos <= sp_c >= ONE_Q28;
			sb_s2.sat_neg <= sp_c <= -ONE_Q28;
			sb_s2.yzero   <= $unsigned(acy_c) < TW'({thr_q, 14'b0});
		end
	end

	// Stage 3: radicand 2^56 - sp^2 for the pitch cosine.
	always_comb begin
		spm_c = (sb_s2.sp < 0) ? $unsigned(-sb_s2.sp) : $unsigned(sb_s2.sp);
		sq_c  = spm_c[27:0] * spm_c[27:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s3 <= sb_s2;
			if (sb_s2.sat_pos || sb_s2.sat_neg) begin
				rem_s3 <= '0;
			end else begin
				rem_s3 <= (RW'(1) << (RW - 1)) - RW'(sq_c);
			end
		end
	end

	assign n_w[0] = rem_s3;
	assign r_w[0] = '0;

	for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
		q2e_isqrt_cell u_sq (
			.clk   (clk),
			.en    (adv),
			.idx   (5'(NSQ - 1 - k)),
			.n_in  (n_w[k]),
			.r_in  (r_w[k]),
			.n_out (n_w[k+1]),
			.r_out (r_w[k+1])
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				sb_d[k] <= (k == 0) ? sb_s3 : sb_d[(k == 0) ? 0 : k - 1];
			end
		end
	end

	q2e_cordic u_roll (
		.clk     (clk),
		.en      (adv),
		.y_in    (CW'(sb_d[NSQ-1].sr)),
		.x_in    (CW'(sb_d[NSQ-1].cr)),
		.ang_out (roll_c)
	);

	q2e_cordic u_pitch (
		.clk     (clk),
		.en      (adv),
		.y_in    (CW'(sb_d[NSQ-1].sp)),
		.x_in    (CW'($signed({1'b0, r_w[NSQ][NSQ-1:0]}))),
		.ang_out (pitch_c)
	);

	q2e_cordic u_yaw (
		.clk     (clk),
		.en      (adv),
		.y_in    (CW'(sb_d[NSQ-1].sy)),
		.x_in    (CW'(sb_d[NSQ-1].cy)),
		.ang_out (yaw_c)
	);

	for (genvar j = 0; j <= N_ITER; j++) begin : g_flags
		always_ff @(posedge clk) begin
			if (adv) begin
				if (j == 0) begin
					fl_d[j] <= '{sat_pos: sb_d[NSQ-1].sat_pos,
					             sat_neg: sb_d[NSQ-1].sat_neg,
					             yzero:   sb_d[NSQ-1].yzero};
				end else begin
					fl_d[j] <= fl_d[(j == 0) ? 0 : j - 1];
				end
			end
		end
	end

	// Stage 4: quadrant correction and pitch wrap.
	always_comb begin
		r_c = roll_c;
		y_c = fl_d[N_ITER].yzero ? '0 : yaw_c;
		if (fl_d[N_ITER].sat_pos) begin
			p_c = ANG_HALF_PI;
		end else if (fl_d[N_ITER].sat_neg) begin
			p_c = -ANG_HALF_PI;
		end else begin
			p_c = pitch_c;
		end
		if (r_c > ANG_HALF_PI && y_c > ANG_HALF_PI) begin
			r_c = r_c - ANG_PI;
			p_c = ANG_PI - p_c;
			y_c = y_c - ANG_PI;
		end else if (r_c < -ANG_HALF_PI && y_c < -ANG_HALF_PI) begin
			r_c = r_c + ANG_PI;
			p_c = ANG_PI - p_c;
			y_c = y_c + ANG_PI;
		end else if (r_c < -ANG_HALF_PI && y_c > ANG_HALF_PI) begin
			r_c = r_c + ANG_PI;
			p_c = ANG_PI - p_c;
			y_c = y_c - ANG_PI;
		end else if (r_c > ANG_HALF_PI && y_c < -ANG_HALF_PI) begin
			r_c = r_c - ANG_PI;
			p_c = -p_c - ANG_PI;
			y_c = y_c + ANG_PI;
		end
		if (p_c < -ANG_PI) begin
			p_c = p_c + ANG_TWO_PI;
		end
		if (p_c > ANG_PI) begin
			p_c = p_c - ANG_TWO_PI;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			roll_s4  <= r_c;
			pitch_s4 <= p_c;
			yaw_s4   <= y_c;
		end
	end

	// Stage 5: quadrant by comparing against multiples of pi/2, then rounding.
	always_comb begin
		pq_c = (pitch_s4 < 0) ? pitch_s4 + ANG_TWO_PI : pitch_s4;
		if (pq_c < 0) begin
			pq_c = '0;
		end
		pq_c   = pq_c + ANG_TENTH;
		quad_c = 3'(pq_c >= AW'(102944)) + 3'(pq_c >= AW'(205888))
		       + 3'(pq_c >= AW'(308832)) + 3'(pq_c >= AW'(411776));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {6'b0, quad_c[1:0], to_out(yaw_s4), to_out(pitch_s4),
			            to_out(roll_s4)};
		end
	end

	a_accept_enters : assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted transfer did not enter the pipeline");

	a_roll_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd25736 &&
		              $signed(m_tdata[15:0]) >= -16'sd25736))
		else $error("roll output beyond saturation limit");

	a_pitch_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd25736 &&
		              $signed(m_tdata[31:16]) >= -16'sd25736))
		else $error("pitch output beyond saturation limit");

	a_stall_holds : assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved while the output was stalled");

endmodule

### hw/rtl/q2e_isqrt_cell.sv
// ---------------------------------------------------------------------------
// q2e_isqrt_cell
// One digit of the restoring integer square root; settles one result bit.
// ---------------------------------------------------------------------------
module q2e_isqrt_cell (
	input  logic                 clk,
	input  logic                 en,
	input  logic [4:0]           idx,
	input  logic [q2e_pkg::RW-1:0] n_in,
	input  logic [q2e_pkg::RW-1:0] r_in,
	output logic [q2e_pkg::RW-1:0] n_out,
	output logic [q2e_pkg::RW-1:0] r_out
);
	import q2e_pkg::*;

	logic [RW-1:0] bit_w;
	logic [RW-1:0] trial;

	assign bit_w = RW'(1) << {idx, 1'b0};
	assign trial = r_in + bit_w;

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_in >= trial) begin
				n_out <= n_in - trial;
				r_out <= (r_in >> 1) + bit_w;
			end else begin
				n_out <= n_in;
				r_out <= r_in >> 1;
			end
		end
	end

endmodule

### hw/rtl/q2e_cordic_cell.sv
// ---------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation driving y toward zero.
// ---------------------------------------------------------------------------
module q2e_cordic_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [4:0]                  idx,
	input  logic signed [q2e_pkg::CW-1:0] x_in,
	input  logic signed [q2e_pkg::CW-1:0] y_in,
	input  logic signed [q2e_pkg::AW-1:0] a_in,
	output logic signed [q2e_pkg::CW-1:0] x_out,
	output logic signed [q2e_pkg::CW-1:0] y_out,
	output logic signed [q2e_pkg::AW-1:0] a_out
);
	import q2e_pkg::*;

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;

	assign dx = y_in >>> idx;
	assign dy = x_in >>> idx;

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 0) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				a_out <= a_in + step_angle(idx);
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				a_out <= a_in - step_angle(idx);
			end
		end
	end

endmodule

### hw/rtl/q2e_cordic.sv
// ---------------------------------------------------------------------------
// q2e_cordic
// Pipelined atan2: a pre-rotation stage followed by a chain of CORDIC cells.
// ---------------------------------------------------------------------------
module q2e_cordic (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [q2e_pkg::CW-1:0] y_in,
	input  logic signed [q2e_pkg::CW-1:0] x_in,
	output logic signed [q2e_pkg::AW-1:0] ang_out
);
	import q2e_pkg::*;

	logic signed [CW-1:0] x_w [N_ITER+1];
	logic signed [CW-1:0] y_w [N_ITER+1];
	logic signed [AW-1:0] a_w [N_ITER+1];
	logic                 zero_q [N_ITER+1];

	// A negative x is turned by pi so that the cells only see the right half plane.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				x_w[0] <= -x_in;
				y_w[0] <= -y_in;
				a_w[0] <= (y_in >= 0) ? ANG_PI : -ANG_PI;
			end else begin
				x_w[0] <= x_in;
				y_w[0] <= y_in;
				a_w[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N_ITER; i++) begin : g_cell
		q2e_cordic_cell u_cell (
			.clk   (clk),
			.en    (en),
			.idx   (5'(i)),
			.x_in  (x_w[i]),
			.y_in  (y_w[i]),
			.a_in  (a_w[i]),
			.x_out (x_w[i+1]),
			.y_out (y_w[i+1]),
			.a_out (a_w[i+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[i+1] <= zero_q[i];
			end
		end
	end

	assign ang_out = zero_q[N_ITER] ? '0 : a_w[N_ITER];

endmodule

### bench/euler_checker.sv
// ---------------------------------------------------------------------------
// euler_checker
// Watches the quaternion input stream, the threshold register and the angle
// output stream. It predicts roll, pitch, yaw and pitch quadrant for every
// accepted quaternion and compares each output transfer with the oldest
// prediction, field by field.
// ---------------------------------------------------------------------------
module euler_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [10:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  quadrant;
		logic [15:0] yaw;
		logic [15:0] pitch;
		logic [15:0] roll;
	} angles_t;

	localparam longint PI_A      = 205887;
	localparam longint HALF_PI_A = 102944;
	localparam longint TWO_PI_A  = 411775;
	localparam longint TENTH_A   = 114;
	localparam longint ONE_A     = 64'sd1 << 28;
	localparam longint SAT_A     = 25736;

	localparam longint ATAN_STEP [0:16] = '{51472, 30386, 16055, 8150, 4091, 2047,
		1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

	logic [10:0] yaw_threshold;
	angles_t     expected_angles [$];

	function automatic longint cordic_atan2(longint y, longint x);
		longint ang;
		longint dx;
		longint dy;
		ang = 0;
		if (x == 0 && y == 0) begin
			return 0;
		end
		if (x < 0) begin
			ang = (y >= 0) ? PI_A : -PI_A;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < q2e_pkg::N_ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y > 0) begin
				x += dx;
				y -= dy;
				ang += (i < 17) ? ATAN_STEP[i] : 0;
			end else begin
				x -= dx;
				y += dy;
				ang -= (i < 17) ? ATAN_STEP[i] : 0;
			end
		end
		return ang;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) begin
			b >>= 2;
		end
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] round_angle(longint a);
		longint v;
		v = (a + 4) >>> 3;
		if (v > SAT_A) begin
			v = SAT_A;
		end
		if (v < -SAT_A) begin
			v = -SAT_A;
		end
		return v[15:0];
	endfunction

	function automatic angles_t predict_angles(logic [63:0] q, logic [10:0] thr);
		longint w, x, y, z, sr, cr, sp, sy, cy, roll, pitch, yaw, acy, p;
		angles_t r;
		w = longint'($signed(q[15:0]));
		x = longint'($signed(q[31:16]));
		y = longint'($signed(q[47:32]));
		z = longint'($signed(q[63:48]));
		sr = 2 * (w * x + y * z);
		cr = ONE_A - 2 * (x * x + y * y);
		sp = 2 * (w * y - z * x);
		sy = 2 * (w * z + x * y);
		cy = ONE_A - 2 * (y * y + z * z);
		roll = cordic_atan2(sr, cr);
		if (sp >= ONE_A) begin
			pitch = HALF_PI_A;
		end else if (sp <= -ONE_A) begin
			pitch = -HALF_PI_A;
		end else begin
			pitch = cordic_atan2(sp, longint'(int_sqrt((64'd1 << 56) - sp * sp)));
		end
		acy = (cy < 0) ? -cy : cy;
		if (acy < (longint'(thr) << 14)) begin
			yaw = 0;
		end else begin
			yaw = cordic_atan2(sy, cy);
		end
		// Both roll and yaw beyond a right angle: fold into the other branch.
		if (roll > HALF_PI_A && yaw > HALF_PI_A) begin
			roll -= PI_A;
			pitch = PI_A - pitch;
			yaw -= PI_A;
		end else if (roll < -HALF_PI_A && yaw < -HALF_PI_A) begin
			roll += PI_A;
			pitch = PI_A - pitch;
			yaw += PI_A;
		end else if (roll < -HALF_PI_A && yaw > HALF_PI_A) begin
			roll += PI_A;
			pitch = PI_A - pitch;
			yaw -= PI_A;
		end else if (roll > HALF_PI_A && yaw < -HALF_PI_A) begin
			roll -= PI_A;
			pitch = -pitch - PI_A;
			yaw += PI_A;
		end
		if (pitch < -PI_A) begin
			pitch += TWO_PI_A;
		end
		if (pitch > PI_A) begin
			pitch -= TWO_PI_A;
		end
		p = (pitch < 0) ? pitch + TWO_PI_A : pitch;
		if (p < 0) begin
			p = 0;
		end
		r.roll = round_angle(roll);
		r.pitch = round_angle(pitch);
		r.yaw = round_angle(yaw);
		r.quadrant = 2'(((p + TENTH_A) / HALF_PI_A) & 3);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what,
			$signed(got), $signed(want));
		errors++;
	endtask

	initial begin
		errors = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		angles_t got;
		angles_t want;
		if (!arst_n) begin
			yaw_threshold <= 11'd1;
			expected_angles.delete();
		end else begin
			if (cfg_wr_en) begin
				yaw_threshold <= cfg_wr_data;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[49:0];
				if (expected_angles.size() == 0) begin
					report_mismatch("output transfer with nothing pending", 16'(got.roll), 16'd0);
				end else begin
					want = expected_angles.pop_front();
					if (got.roll != want.roll) begin
						report_mismatch("roll", got.roll, want.roll);
					end
					if (got.pitch != want.pitch) begin
						report_mismatch("pitch", got.pitch, want.pitch);
					end
					if (got.yaw != want.yaw) begin
						report_mismatch("yaw", got.yaw, want.yaw);
					end
					if (got.quadrant != want.quadrant) begin
						report_mismatch("quadrant", 16'(got.quadrant), 16'(want.quadrant));
					end
				end
				if (m_tdata[55:50] != '0) begin
					report_mismatch("padding bits", 16'(m_tdata[55:50]), 16'd0);
				end
			end
			if (s_tvalid && s_tready) begin
				expected_angles.push_back(predict_angles(s_tdata, yaw_threshold));
			end
		end
		pending = expected_angles.size();
	end

endmodule

### bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives quaternions into the Euler angle converter under several threshold
// settings and idle patterns, and gives the verdict from the checker.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 70;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          recv_idle_pct;
	logic        hold_output;
	int          cycle_count;

	quaternion_to_euler_angles u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	euler_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	// Receiver side: random stalls, plus one long hold-off on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_output) begin
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_output = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_quat(logic [63:0] q);
		logic ok;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= q;
		do begin
			#2;
			ok = s_tready;
			@(negedge clk);
		end while (!ok);
	endtask

	task automatic write_threshold(logic [10:0] v);
		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [63:0] pack_quat(int w, int x, int y, int z);
		return {16'(z), 16'(y), 16'(x), 16'(w)};
	endfunction

	function automatic logic [15:0] random_part();
		return 16'($urandom_range(32768) - 16384);
	endfunction

	function automatic logic [63:0] random_quat();
		int sel;
		sel = $urandom_range(9);
		if (sel == 0) begin
			return {$urandom, $urandom};
		end else if (sel == 1) begin
			// Pitch term close to or past one.
			return pack_quat(11585 + $urandom_range(40) - 20, $urandom_range(600) - 300,
				11585 + $urandom_range(40) - 20, $urandom_range(600) - 300);
		end else begin
			return {random_part(), random_part(), random_part(), random_part()};
		end
	endfunction

	task automatic send_directed();
		send_quat(pack_quat(16384, 0, 0, 0));
		send_quat(pack_quat(-16384, 0, 0, 0));
		send_quat(pack_quat(0, 16384, 0, 0));
		send_quat(pack_quat(0, 0, 16384, 0));
		send_quat(pack_quat(0, 0, 0, 16384));
		send_quat(pack_quat(0, 0, -16384, 0));
		send_quat(pack_quat(11585, 0, 11585, 0));
		send_quat(pack_quat(11585, 0, -11585, 0));
		send_quat(pack_quat(11586, 0, 11586, 0));
		send_quat(pack_quat(0, 0, 0, 0));
		send_quat(pack_quat(0, 8192, 8192, 0));
		send_quat(pack_quat(0, 0, 8192, 8192));
		send_quat(pack_quat(0, 8192, 0, 8192));
		send_quat(pack_quat(16384, 16384, 16384, 16384));
		send_quat(pack_quat(-16384, -16384, -16384, -16384));
		send_quat(pack_quat(-32768, -32768, -32768, -32768));
		send_quat(pack_quat(32767, 32767, 32767, 32767));
		send_quat(pack_quat(32767, -32768, 32767, -32768));
		send_quat(pack_quat(1000, 15000, 1000, 6000));
		send_quat(pack_quat(1000, -15000, 1000, 6000));
		send_quat(pack_quat(1000, 15000, -1000, -6000));
		send_quat(pack_quat(-1000, -15000, 2000, -6000));
		send_quat(pack_quat(0, 12000, 0, 0) | {16'd0, 16'd0, 16'd0, 16'd11000});
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		hold_output = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 74;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_directed();
		for (int i = 0; i < 250; i++) begin
			send_quat(random_quat());
		end
		write_threshold(11'd0);
		send_directed();
		for (int i = 0; i < 250; i++) begin
			send_quat(random_quat());
		end

		send_idle_pct = 74;
		recv_idle_pct = 11;
		write_threshold(11'd1024);
		send_directed();
		for (int i = 0; i < 250; i++) begin
			send_quat(random_quat());
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_threshold(11'($urandom_range(1024)));
		hold_output = 1'b1;
		for (int i = 0; i < 250; i++) begin
			send_quat(random_quat());
		end
		write_threshold(11'd2047);
		for (int i = 0; i < 200; i++) begin
			send_quat(random_quat());
		end

		s_tvalid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
